[src/tsam_pkg.sv]
// ----------------------------------------------------------------------------
// Touch sample averager package
// Shared widths, register indexes, phase codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package tsam_pkg;

    localparam int SAMPLES   = 6;
    localparam int RAW_W     = 12;
    localparam int SCR_W     = 16;
    localparam int SUM_W     = 16;
    localparam int DIV_W     = 13;
    localparam int CNT_W     = $clog2(SAMPLES + 1);
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int REG_IDX_W = 3;

    // Average by reciprocal multiply: exact for any 16-bit sum and 1..16 samples
    localparam int AVG_SHIFT = 20;
    localparam int RECIP_W   = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((2 ** AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

    localparam logic [REG_IDX_W-1:0] REG_X_LO   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_HI   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_LO   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_HI   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_H_LAST = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_W_LAST = 3'd5;

    localparam logic [RAW_W-1:0] RST_LO     = 12'd0;
    localparam logic [RAW_W-1:0] RST_HI     = 12'h0FFF;
    localparam logic [RAW_W-1:0] RST_H_LAST = 12'd319;
    localparam logic [RAW_W-1:0] RST_W_LAST = 12'd239;

    localparam logic [SCR_W-1:0] X_SHIFT = 16'd10;
    localparam logic [SCR_W-1:0] Y_SHIFT = 16'd18;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_AVG  = 2'd0;
    localparam t_phase PH_BAND = 2'd1;
    localparam t_phase PH_MAP  = 2'd2;

    typedef struct packed {
        logic   capture;
        logic   accum;
        logic   clear;
        logic   div_start;
        logic   div_load;
        t_phase phase;
        logic   emit_press;
        logic   emit_release;
    } t_cmd;

    typedef struct packed {
        logic pen;
        logic in_window;
        logic last_sample;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

[src/tsam_if.sv]
// ----------------------------------------------------------------------------
// Touch sample averager channels
// Sample request, result request and register write channels.
// ----------------------------------------------------------------------------
interface tsam_in_if;
    logic                        valid;
    logic                        ready;
    logic                        pen_down;
    logic [tsam_pkg::RAW_W-1:0]  raw_x;
    logic [tsam_pkg::RAW_W-1:0]  raw_y;

    modport source (output valid, output pen_down, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input pen_down, input raw_x, input raw_y, output ready);
endinterface

interface tsam_out_if;
    logic                        valid;
    logic                        ready;
    logic                        touched;
    logic [tsam_pkg::SCR_W-1:0]  screen_x;
    logic [tsam_pkg::SCR_W-1:0]  screen_y;

    modport source (output valid, output touched, output screen_x, output screen_y,
                    input ready);
    modport sink   (input valid, input touched, input screen_x, input screen_y,
                    output ready);
endinterface

interface tsam_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsam_pkg::REG_IDX_W-1:0]  addr;
    logic [tsam_pkg::RAW_W-1:0]      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/tsam_div.sv]
// ----------------------------------------------------------------------------
// Touch sample averager divider
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module tsam_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tsam_pkg::SUM_W-1:0]   i_dividend,
    input  logic [tsam_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [tsam_pkg::SUM_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [tsam_pkg::STEP_W-1:0]   r_step;
    logic [tsam_pkg::SUM_W-1:0]    r_quo;
    logic [tsam_pkg::DIV_W-1:0]    r_rem;
    logic [tsam_pkg::DIV_W-1:0]    r_dsr;

    logic [tsam_pkg::DIV_W:0]      trial;
    logic [tsam_pkg::DIV_W:0]      diff;
    logic                          ge;
    logic [tsam_pkg::DIV_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[tsam_pkg::SUM_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[tsam_pkg::DIV_W-1:0] : trial[tsam_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + tsam_pkg::STEP_W'(1);
                if (r_step == tsam_pkg::STEP_W'(tsam_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tsam_pkg::SUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/tsam_dp.sv]
// ----------------------------------------------------------------------------
// Touch sample averager datapath
// Registers, window compare, sums, reciprocal average, two divider lanes and
// result register.
// ----------------------------------------------------------------------------
module tsam_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsam_pkg::t_cmd                   i_cmd,
    output tsam_pkg::t_stat                  o_stat,
    input  logic                             i_pen_down,
    input  logic [tsam_pkg::RAW_W-1:0]       i_raw_x,
    input  logic [tsam_pkg::RAW_W-1:0]       i_raw_y,
    input  logic                             i_cfg_we,
    input  logic [tsam_pkg::REG_IDX_W-1:0]   i_cfg_addr,
    input  logic [tsam_pkg::RAW_W-1:0]       i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_out_touched,
    output logic [tsam_pkg::SCR_W-1:0]       o_out_screen_x,
    output logic [tsam_pkg::SCR_W-1:0]       o_out_screen_y
);

    logic [tsam_pkg::RAW_W-1:0]  r_x_lo, r_x_hi, r_y_lo, r_y_hi, r_h_last, r_w_last;
    logic                        r_pen;
    logic [tsam_pkg::RAW_W-1:0]  r_rx, r_ry;
    logic [tsam_pkg::CNT_W-1:0]  r_count;
    logic [tsam_pkg::SUM_W-1:0]  r_sum_x, r_sum_y;
    logic [tsam_pkg::SUM_W-1:0]  r_avg_x, r_avg_y;
    logic [tsam_pkg::DIV_W-1:0]  r_div_x, r_div_y;
    logic [tsam_pkg::SCR_W-1:0]  r_scr_x, r_scr_y;
    logic                        r_out_valid, r_out_touched;
    logic [tsam_pkg::SCR_W-1:0]  r_out_x, r_out_y;

    logic [tsam_pkg::RAW_W-1:0]  band_x, band_y;
    logic [tsam_pkg::SUM_W-1:0]  dvd_x, dvd_y, q_x, q_y;
    logic [tsam_pkg::DIV_W-1:0]  dsr_x, dsr_y;
    logic                        done_x, done_y;
    logic [tsam_pkg::SUM_W+tsam_pkg::RECIP_W-1:0] prod_x, prod_y;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo   <= tsam_pkg::RST_LO;
            r_x_hi   <= tsam_pkg::RST_HI;
            r_y_lo   <= tsam_pkg::RST_LO;
            r_y_hi   <= tsam_pkg::RST_HI;
            r_h_last <= tsam_pkg::RST_H_LAST;
            r_w_last <= tsam_pkg::RST_W_LAST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tsam_pkg::REG_X_LO:   r_x_lo   <= i_cfg_data;
                tsam_pkg::REG_X_HI:   r_x_hi   <= i_cfg_data;
                tsam_pkg::REG_Y_LO:   r_y_lo   <= i_cfg_data;
                tsam_pkg::REG_Y_HI:   r_y_hi   <= i_cfg_data;
                tsam_pkg::REG_H_LAST: r_h_last <= i_cfg_data;
                tsam_pkg::REG_W_LAST: r_w_last <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pen <= i_pen_down;
            r_rx  <= i_raw_x;
            r_ry  <= i_raw_y;
        end
    end

    // Running sums, dropped on a release or after a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.accum) begin
            r_count <= r_count + tsam_pkg::CNT_W'(1);
            r_sum_x <= r_sum_x + tsam_pkg::SUM_W'(r_rx);
            r_sum_y <= r_sum_y + tsam_pkg::SUM_W'(r_ry);
        end
    end

    // Divide the sums by SAMPLES through a rounded-up reciprocal
    assign prod_x = (tsam_pkg::SUM_W + tsam_pkg::RECIP_W)'(r_sum_x) *
                    (tsam_pkg::SUM_W + tsam_pkg::RECIP_W)'(tsam_pkg::AVG_RECIP);
    assign prod_y = (tsam_pkg::SUM_W + tsam_pkg::RECIP_W)'(r_sum_y) *
                    (tsam_pkg::SUM_W + tsam_pkg::RECIP_W)'(tsam_pkg::AVG_RECIP);

    // Inverted window gives an empty band
    assign band_x = (r_x_hi > r_x_lo) ? (r_x_hi - r_x_lo) : '0;
    assign band_y = (r_y_hi > r_y_lo) ? (r_y_hi - r_y_lo) : '0;

    always_comb begin
        case (i_cmd.phase)
            tsam_pkg::PH_BAND: begin
                dvd_x = tsam_pkg::SUM_W'(band_x);
                dvd_y = tsam_pkg::SUM_W'(band_y);
                dsr_x = {1'b0, r_h_last} + tsam_pkg::DIV_W'(1);
                dsr_y = {1'b0, r_w_last} + tsam_pkg::DIV_W'(1);
            end
            default: begin
                dvd_x = r_avg_x;
                dvd_y = r_avg_y;
                dsr_x = r_div_x;
                dsr_y = r_div_y;
            end
        endcase
    end

    tsam_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd_x),
        .i_divisor  (dsr_x),
        .o_done     (done_x),
        .o_quotient (q_x)
    );

    tsam_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd_y),
        .i_divisor  (dsr_y),
        .o_done     (done_y),
        .o_quotient (q_y)
    );

    // Store each phase's quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            case (i_cmd.phase)
                tsam_pkg::PH_AVG: begin
                    r_avg_x <= prod_x[tsam_pkg::AVG_SHIFT +: tsam_pkg::SUM_W];
                    r_avg_y <= prod_y[tsam_pkg::AVG_SHIFT +: tsam_pkg::SUM_W];
                end
                tsam_pkg::PH_BAND: begin
                    r_div_x <= q_x[tsam_pkg::DIV_W-1:0] + tsam_pkg::DIV_W'(1);
                    r_div_y <= q_y[tsam_pkg::DIV_W-1:0] + tsam_pkg::DIV_W'(1);
                end
                tsam_pkg::PH_MAP: begin
                    r_scr_x <= tsam_pkg::SCR_W'(r_h_last) + tsam_pkg::SCR_W'(1)
                               - (q_x - tsam_pkg::X_SHIFT);
                    r_scr_y <= q_y - tsam_pkg::Y_SHIFT;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_press || i_cmd.emit_release) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_press) begin
            r_out_touched <= 1'b1;
            r_out_x       <= r_scr_x;
            r_out_y       <= r_scr_y;
        end else if (i_cmd.emit_release) begin
            r_out_touched <= 1'b0;
            r_out_x       <= '0;
            r_out_y       <= '0;
        end
    end

    always_comb begin
        o_stat.pen         = r_pen;
        o_stat.in_window   = (r_rx > r_x_lo) && (r_rx < r_x_hi) &&
                             (r_ry > r_y_lo) && (r_ry < r_y_hi);
        o_stat.last_sample = (r_count == tsam_pkg::CNT_W'(tsam_pkg::SAMPLES - 1));
        o_stat.div_done    = done_x && done_y;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_touched  = r_out_touched;
    assign o_out_screen_x = r_out_x;
    assign o_out_screen_y = r_out_y;

endmodule

[src/tsam_ctrl.sv]
// ----------------------------------------------------------------------------
// Touch sample averager controller
// Sequences capture, window check, averaging, two divide phases and result
// emission.
// ----------------------------------------------------------------------------
module tsam_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tsam_pkg::t_stat  i_stat,
    output tsam_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_AVG       = 4'd2;
    localparam logic [3:0] S_BAND_GO   = 4'd3;
    localparam logic [3:0] S_BAND_WAIT = 4'd4;
    localparam logic [3:0] S_MAP_GO    = 4'd5;
    localparam logic [3:0] S_MAP_WAIT  = 4'd6;
    localparam logic [3:0] S_EMIT      = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.pen) begin
                    // hold the release until the result register frees up
                    if (i_stat.out_free) begin
                        o_cmd.emit_release = 1'b1;
                        o_cmd.clear        = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else if (i_stat.in_window) begin
                    o_cmd.accum = 1'b1;
                    n_state     = i_stat.last_sample ? S_AVG : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_AVG: begin
                // latch the reciprocal-multiply averages
                o_cmd.phase    = tsam_pkg::PH_AVG;
                o_cmd.div_load = 1'b1;
                n_state        = S_BAND_GO;
            end
            S_BAND_GO: begin
                o_cmd.phase     = tsam_pkg::PH_BAND;
                o_cmd.div_start = 1'b1;
                n_state         = S_BAND_WAIT;
            end
            S_BAND_WAIT: begin
                o_cmd.phase = tsam_pkg::PH_BAND;
                if (i_stat.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_MAP_GO;
                end
            end
            S_MAP_GO: begin
                o_cmd.phase     = tsam_pkg::PH_MAP;
                o_cmd.div_start = 1'b1;
                n_state         = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                o_cmd.phase = tsam_pkg::PH_MAP;
                if (i_stat.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_press = 1'b1;
                    o_cmd.clear      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/touch_sample_average_mapper_top.sv]
// ----------------------------------------------------------------------------
// Touch sample average mapper
// Averages in-window touch conversions and maps the average to screen pixels.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one request per conversion: pen_down, raw_x, raw_y.
//   o_out  carries one result request: touched, screen_x, screen_y.
//   i_cfg  writes the six 12-bit registers (window limits, last pixel indexes)
//          by addr; it is always ready and is meant for use while idle.
// Sequencing:
//   A request that is rejected or only adds to the sums passes through
//   capture and check, and the next request is taken only once the
//   controller is back in idle. A pen-up request emits its not-touched result
//   from the check state once the result register is free. The request that
//   completes a set of SAMPLES averages the sums by reciprocal multiply, then
//   runs two divide phases (axis step, pixel scale) on two 16-step restoring
//   dividers (x and y lanes) before its result is emitted.
// Reset:
//   Synchronous, active low. Registers return to full window, 319 and 239;
//   sums and count clear; no result is pending.
// Stall:
//   The result register holds while o_out.ready is low; new requests are still
//   accepted and summed, and the next result waits until the register frees.
// ----------------------------------------------------------------------------
module touch_sample_average_mapper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsam_in_if.sink    i_in,
    tsam_out_if.source o_out,
    tsam_cfg_if.sink   i_cfg
);

    tsam_pkg::t_cmd  cmd;
    tsam_pkg::t_stat stat;

    // Register writes never stall
    assign i_cfg.ready = 1'b1;

    tsam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsam_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_pen_down     (i_in.pen_down),
        .i_raw_x        (i_in.raw_x),
        .i_raw_y        (i_in.raw_y),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_addr     (i_cfg.addr),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_touched  (o_out.touched),
        .o_out_screen_x (o_out.screen_x),
        .o_out_screen_y (o_out.screen_y)
    );

endmodule

[src/tsam_chk.sv]
// ----------------------------------------------------------------------------
// Touch sample averager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tsam_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_touched,
    input logic [tsam_pkg::SCR_W-1:0]   i_out_screen_x,
    input logic [tsam_pkg::SCR_W-1:0]   i_out_screen_y
);

    // Result register clears out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result pending after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_touched) &&
            $stable(i_out_screen_x) && $stable(i_out_screen_y))
        else $error("stalled result changed");

    // A release carries a zero point
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_touched |->
            i_out_screen_x == '0 && i_out_screen_y == '0)
        else $error("release with nonzero point");

    // A fresh result follows a cycle in which no request was taken
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while idle");

endmodule

bind touch_sample_average_mapper_top tsam_chk u_tsam_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_touched  (o_out.touched),
    .i_out_screen_x (o_out.screen_x),
    .i_out_screen_y (o_out.screen_y)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Touch sample average mapper testbench
// Drives sample requests through several register settings, predicts each
// pressed or not-touched result, and compares results in order as they leave.
// ----------------------------------------------------------------------------
module testbench;

    // Register indexes that map to no register; writes there must be ignored.
    localparam logic [tsam_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [tsam_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int MAX_GAP     = 17;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE      = 80;
    localparam int LIMIT_TICKS = 8 * 800_000;

    typedef struct packed {
        logic                       touched;
        logic [tsam_pkg::SCR_W-1:0] screen_x;
        logic [tsam_pkg::SCR_W-1:0] screen_y;
    } t_touch_point;

    // Running sums, window registers and the queue of points still owed.
    class t_touch_ledger;
        logic [tsam_pkg::RAW_W-1:0] x_lo, x_hi, y_lo, y_hi, h_last, w_last;
        logic [3:0]                 taken;
        logic [tsam_pkg::SUM_W-1:0] sum_x, sum_y;
        t_touch_point               due[$];
        int                         mismatches;

        function new();
            x_lo       = tsam_pkg::RST_LO;
            x_hi       = tsam_pkg::RST_HI;
            y_lo       = tsam_pkg::RST_LO;
            y_hi       = tsam_pkg::RST_HI;
            h_last     = tsam_pkg::RST_H_LAST;
            w_last     = tsam_pkg::RST_W_LAST;
            mismatches = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            taken = '0;
            sum_x = '0;
            sum_y = '0;
        endfunction

        function void set_register(logic [tsam_pkg::REG_IDX_W-1:0] idx,
                                   logic [tsam_pkg::RAW_W-1:0] val);
            case (idx)
                tsam_pkg::REG_X_LO:   x_lo   = val;
                tsam_pkg::REG_X_HI:   x_hi   = val;
                tsam_pkg::REG_Y_LO:   y_lo   = val;
                tsam_pkg::REG_Y_HI:   y_hi   = val;
                tsam_pkg::REG_H_LAST: h_last = val;
                tsam_pkg::REG_W_LAST: w_last = val;
                default: ;
            endcase
        endfunction

        // Raw counts per pixel; an empty or inverted band gives a step of one.
        function int unsigned axis_step(int unsigned lo, int unsigned hi,
                                        int unsigned last);
            int unsigned band;
            band = (hi > lo) ? hi - lo : 0;
            return band / (last + 1) + 1;
        endfunction

        // Note one accepted request; queue the result it owes, if any.
        function void note_sample(logic pen, logic [tsam_pkg::RAW_W-1:0] rx,
                                  logic [tsam_pkg::RAW_W-1:0] ry);
            int unsigned  mean_x, mean_y, span_x, col, row;
            t_touch_point pt;
            if (!pen) begin
                clear_sums();
                pt = '0;
                due.push_back(pt);
                return;
            end
            if (!(rx > x_lo && rx < x_hi && ry > y_lo && ry < y_hi))
                return;
            sum_x = sum_x + tsam_pkg::SUM_W'(rx);
            sum_y = sum_y + tsam_pkg::SUM_W'(ry);
            taken = taken + 1'b1;
            if (taken < tsam_pkg::SAMPLES)
                return;
            mean_x = sum_x;
            mean_y = sum_y;
            mean_x = mean_x / tsam_pkg::SAMPLES;
            mean_y = mean_y / tsam_pkg::SAMPLES;
            span_x = h_last;
            span_x = span_x + 1;
            col = span_x - (mean_x / axis_step(x_lo, x_hi, h_last) - tsam_pkg::X_SHIFT);
            row = mean_y / axis_step(y_lo, y_hi, w_last) - tsam_pkg::Y_SHIFT;
            pt.touched  = 1'b1;
            pt.screen_x = col[tsam_pkg::SCR_W-1:0];
            pt.screen_y = row[tsam_pkg::SCR_W-1:0];
            due.push_back(pt);
            clear_sums();
        endfunction

        function void check_point(t_touch_point got);
            t_touch_point want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected touch result: touched=%0d x=%0d y=%0d",
                             got.touched, got.screen_x, got.screen_y);
                return;
            end
            want = due.pop_front();
            if (got.touched !== want.touched || got.screen_x !== want.screen_x ||
                got.screen_y !== want.screen_y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"touch result mismatch: expected touched=%0d x=%0d y=%0d, ",
                              "got touched=%0d x=%0d y=%0d"},
                             want.touched, want.screen_x, want.screen_y,
                             got.touched, got.screen_x, got.screen_y);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_request;

    tsam_in_if  in_ch ();
    tsam_out_if out_ch ();
    tsam_cfg_if cfg_ch ();

    t_touch_ledger ledger = new();

    touch_sample_average_mapper_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(LIMIT_TICKS);
        $display("end of test: mismatches");
        $finish;
    end

    // Draw a wait length; flip now and then into a calm stretch with no waits.
    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Pick a coordinate aimed at the window, leaning on its edges (limits included).
    function automatic logic [tsam_pkg::RAW_W-1:0] pick_axis(
        logic [tsam_pkg::RAW_W-1:0] lo, logic [tsam_pkg::RAW_W-1:0] hi);
        int unsigned l, h, r;
        l = lo;
        h = hi;
        r = $urandom_range(0, 15);
        if (h <= l + 1)
            return tsam_pkg::RAW_W'($urandom);
        case (r)
            0:       return lo;
            1:       return hi;
            2:       return tsam_pkg::RAW_W'(l + 1);
            3:       return tsam_pkg::RAW_W'(h - 1);
            default: return tsam_pkg::RAW_W'($urandom_range(l + 1, h - 1));
        endcase
    endfunction

    bit send_calm;

    // Offer one sample request after a random gap, hold it until accepted.
    task automatic send_sample(input logic pen, input logic [tsam_pkg::RAW_W-1:0] rx,
                               input logic [tsam_pkg::RAW_W-1:0] ry);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pen_down <= pen;
        in_ch.raw_x    <= rx;
        in_ch.raw_y    <= ry;
        do @(posedge clk); while (!in_ch.ready);
        ledger.note_sample(pen, rx, ry);
    endtask

    task automatic put_register(input logic [tsam_pkg::REG_IDX_W-1:0] idx,
                                input logic [tsam_pkg::RAW_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        ledger.set_register(idx, val);
    endtask

    task automatic load_window(input logic [tsam_pkg::RAW_W-1:0] xlo,
                               input logic [tsam_pkg::RAW_W-1:0] xhi,
                               input logic [tsam_pkg::RAW_W-1:0] ylo,
                               input logic [tsam_pkg::RAW_W-1:0] yhi,
                               input logic [tsam_pkg::RAW_W-1:0] hl,
                               input logic [tsam_pkg::RAW_W-1:0] wl);
        put_register(tsam_pkg::REG_X_LO, xlo);
        put_register(tsam_pkg::REG_X_HI, xhi);
        put_register(tsam_pkg::REG_Y_LO, ylo);
        put_register(tsam_pkg::REG_Y_HI, yhi);
        put_register(tsam_pkg::REG_H_LAST, hl);
        put_register(tsam_pkg::REG_W_LAST, wl);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain all owed results, then let rejected or summing requests finish.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (ledger.due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Strokes of pen-down requests, mostly inside the window, often closed by
    // a pen-up; every request sent counts toward the budget.
    task automatic run_strokes(input int budget);
        int sent, len, kind;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 80)
                    send_sample(1'b1, pick_axis(ledger.x_lo, ledger.x_hi),
                                pick_axis(ledger.y_lo, ledger.y_hi));
                else if (kind < 95)
                    send_sample(1'b1, tsam_pkg::RAW_W'($urandom),
                                tsam_pkg::RAW_W'($urandom));
                else
                    send_sample(1'b0, tsam_pkg::RAW_W'($urandom),
                                tsam_pkg::RAW_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 1)) begin
                send_sample(1'b0, tsam_pkg::RAW_W'($urandom), tsam_pkg::RAW_W'($urandom));
                sent++;
            end
        end
    endtask

    // Result side: random ready gaps, plus one long hold-off when requested
    // so that the result register fills and the input side stalls.
    initial begin
        int  gap;
        bit  calm;
        t_touch_point got;
        calm = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = draw_gap(calm);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.touched  = out_ch.touched;
            got.screen_x = out_ch.screen_x;
            got.screen_y = out_ch.screen_y;
            ledger.check_point(got);
        end
    end

    // Request side and register writes.
    initial begin
        hold_request = 1'b0;
        send_calm    = 1'b0;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.pen_down <= 1'b0;
        in_ch.raw_x    <= '0;
        in_ch.raw_y    <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.addr    <= tsam_pkg::REG_X_LO;
        cfg_ch.data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks on the reset window (0..4095, 319 x 239).
        // Pen up with every raw bit set: not-touched with a zero point.
        send_sample(1'b0, 12'hFFF, 12'hFFF);
        // Coordinates sitting on the window limits are rejected.
        send_sample(1'b1, 12'd0,    12'd2000);
        send_sample(1'b1, 12'hFFF,  12'd2000);
        send_sample(1'b1, 12'd2000, 12'd0);
        send_sample(1'b1, 12'd2000, 12'hFFF);
        // Lowest accepted corner: screen x beyond the panel, screen y wraps.
        repeat (tsam_pkg::SAMPLES) send_sample(1'b1, 12'd1, 12'd1);
        // Highest accepted corner, with a rejected pair in the middle.
        repeat (3) send_sample(1'b1, 12'd4094, 12'd4094);
        send_sample(1'b1, 12'd4094, 12'd0);
        repeat (tsam_pkg::SAMPLES - 3) send_sample(1'b1, 12'd4094, 12'd4094);
        // Partial set dropped by a pen-up.
        repeat (3) send_sample(1'b1, 12'd2048, 12'd1024);
        send_sample(1'b0, 12'h555, 12'hAAA);
        run_strokes(220);

        // Largest screen: one raw count per pixel. Hold the result side off
        // for a long stretch while requests keep coming.
        wait_idle();
        load_window(12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF);
        hold_request = 1'b1;
        run_strokes(220);

        // Single-pixel screen: the whole band collapses into one step.
        wait_idle();
        load_window(12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 12'd0);
        run_strokes(200);

        // Narrow window: only two codes pass on x and three on y.
        wait_idle();
        load_window(12'd2000, 12'd2003, 12'd100, 12'd104,
                    tsam_pkg::RST_H_LAST, tsam_pkg::RST_W_LAST);
        run_strokes(200);

        // Random window and screen size.
        wait_idle();
        load_window(tsam_pkg::RAW_W'($urandom_range(0, 2000)),
                    tsam_pkg::RAW_W'($urandom_range(2100, 4095)),
                    tsam_pkg::RAW_W'($urandom_range(0, 2000)),
                    tsam_pkg::RAW_W'($urandom_range(2100, 4095)),
                    tsam_pkg::RAW_W'($urandom), tsam_pkg::RAW_W'($urandom));
        run_strokes(220);

        // Inverted x window and closed y window: only pen-ups produce results.
        // Writes to the spare indexes must not disturb any register.
        wait_idle();
        load_window(12'd3000, 12'd1000, 12'd2048, 12'd2048,
                    tsam_pkg::RAW_W'($urandom), tsam_pkg::RAW_W'($urandom));
        put_register(REG_SPARE_A, tsam_pkg::RAW_W'($urandom));
        put_register(REG_SPARE_B, tsam_pkg::RAW_W'($urandom));
        cfg_ch.valid <= 1'b0;
        run_strokes(25);

        // Another random setting, sums left pending from the closed window.
        wait_idle();
        load_window(tsam_pkg::RAW_W'($urandom_range(0, 1000)),
                    tsam_pkg::RAW_W'($urandom_range(3000, 4095)),
                    tsam_pkg::RAW_W'($urandom_range(0, 1000)),
                    tsam_pkg::RAW_W'($urandom_range(3000, 4095)),
                    tsam_pkg::RAW_W'($urandom_range(0, 639)),
                    tsam_pkg::RAW_W'($urandom_range(0, 479)));
        run_strokes(220);

        // Back to the reset values.
        wait_idle();
        load_window(tsam_pkg::RST_LO, tsam_pkg::RST_HI, tsam_pkg::RST_LO, tsam_pkg::RST_HI,
                    tsam_pkg::RST_H_LAST, tsam_pkg::RST_W_LAST);
        run_strokes(150);

        // Drain, then give any last summing request time to settle.
        wait_idle();
        if (ledger.mismatches == 0 && ledger.due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
